@@ hw/rtl/kwm_pkg.sv @@
package kwm_pkg;

   localparam int KEYWORD_CHARS = 8;
   localparam int CHAR_W        = 8;
   localparam int KEY_DATA_W    = 64;
   localparam int KEY_LEN_W     = 4;
   // counts run up to KEYWORD_CHARS + 1 (word position saturation)
   localparam int KEY_CNT_W     = $clog2(KEYWORD_CHARS + 2);
   localparam int KW_IDX_W      = (KEYWORD_CHARS > 1) ? $clog2(KEYWORD_CHARS) : 1;
   localparam int CSR_INDEX_W   = 2;

   localparam logic [CHAR_W-1:0] SPACE_CHAR = 8'h20;
   localparam logic [CHAR_W-1:0] DASH_CHAR  = 8'h2d;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_MATCH_MODE     = 2'd0,
      CSR_KEYWORD_BYTES  = 2'd1,
      CSR_KEYWORD_LENGTH = 2'd2
   } csr_index_type;

   typedef enum logic {
      MODE_SUBSTRING  = 1'b0,
      MODE_WHOLE_WORD = 1'b1
   } match_mode_type;

   // keyword as seen by the match core: already lowercased, length clipped
   typedef struct packed {
      match_mode_type                        mode;
      logic [KEYWORD_CHARS-1:0][CHAR_W-1:0]  key;
      logic [KEY_CNT_W-1:0]                  key_len;
   } kwm_cfg_type;

   function automatic logic [CHAR_W-1:0] to_lower(input logic [CHAR_W-1:0] c);
      logic [CHAR_W-1:0] r;
      r = c;
      if (c >= 8'h41 && c <= 8'h5a) begin
         r = c + 8'd32;
      end
      return r;
   endfunction

   function automatic logic is_alnum(input logic [CHAR_W-1:0] c);
      return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5a) ||
             (c >= 8'h61 && c <= 8'h7a);
   endfunction

endpackage

@@ hw/rtl/kwm_csr.sv @@
module kwm_csr
   import kwm_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [KEY_DATA_W-1:0]  csr_data,
   output kwm_cfg_type            cfg
);

   match_mode_type                       mode_ff;
   logic [KEYWORD_CHARS-1:0][CHAR_W-1:0] key_ff;
   logic [KEY_LEN_W-1:0]                 len_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_SUBSTRING;
         key_ff  <= '0;
         len_ff  <= '0;
      end else if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_MATCH_MODE: begin
               mode_ff <= match_mode_type'(csr_data[0]);
            end
            CSR_KEYWORD_BYTES: begin
               for (int i = 0; i < KEYWORD_CHARS; i++) begin
                  key_ff[i] <= to_lower(csr_data[i*CHAR_W +: CHAR_W]);
               end
            end
            CSR_KEYWORD_LENGTH: begin
               len_ff <= csr_data[KEY_LEN_W-1:0];
            end
            default: begin
               // unused index, write dropped
            end
         endcase
      end
   end

   always_comb begin
      cfg.mode = mode_ff;
      cfg.key  = key_ff;
      if (len_ff > KEY_LEN_W'(KEYWORD_CHARS)) begin
         cfg.key_len = KEY_CNT_W'(KEYWORD_CHARS);
      end else begin
         cfg.key_len = KEY_CNT_W'(len_ff);
      end
   end

endmodule

@@ hw/rtl/kwm_match_core.sv @@
module kwm_match_core
   import kwm_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  kwm_cfg_type       cfg,
   input  logic              step_valid,
   input  logic [CHAR_W-1:0] step_char,
   input  logic              step_eol,
   output logic              hit
);

   typedef enum logic [1:0] {
      DASH_NONE       = 2'd0,
      DASH_SPACE      = 2'd1,
      DASH_SPACE_DASH = 2'd2
   } dash_type;

   logic [KEYWORD_CHARS-1:0][CHAR_W-1:0] recent_ff, recent_in;
   logic [KEY_CNT_W-1:0] fill_ff, fill_in;
   logic                 nonempty_ff, nonempty_in;
   logic                 seen_ff, seen_in;
   logic [KEY_CNT_W-1:0] pos_ff, pos_in;
   logic                 mism_ff, mism_in;
   dash_type             dash_ff, dash_in;
   logic                 trunc_ff, trunc_in;

   logic [CHAR_W-1:0]    lc;
   logic                 win_eq;
   logic                 word_hit;
   logic [KEY_CNT_W-1:0] kidx;

   assign lc       = to_lower(step_char);
   assign word_hit = (pos_ff != '0) && (cfg.key_len != '0) &&
                     (pos_ff == cfg.key_len) && !mism_ff;

   // window after the shift; oldest used byte lines up with keyword byte 0
   always_comb begin
      recent_in[0] = lc;
      for (int j = 1; j < KEYWORD_CHARS; j++) begin
         recent_in[j] = recent_ff[j-1];
      end
      win_eq = 1'b1;
      for (int j = 0; j < KEYWORD_CHARS; j++) begin
         kidx = cfg.key_len - KEY_CNT_W'(j + 1);
         if (KEY_CNT_W'(j) < cfg.key_len &&
             recent_in[j] != cfg.key[kidx[KW_IDX_W-1:0]]) begin
            win_eq = 1'b0;
         end
      end
   end

   always_comb begin
      fill_in     = fill_ff;
      nonempty_in = nonempty_ff;
      seen_in     = seen_ff;
      pos_in      = pos_ff;
      mism_in     = mism_ff;
      dash_in     = dash_ff;
      trunc_in    = trunc_ff;
      if (step_valid) begin
         if (step_eol) begin
            fill_in     = '0;
            nonempty_in = 1'b0;
            seen_in     = 1'b0;
            pos_in      = '0;
            mism_in     = 1'b0;
            dash_in     = DASH_NONE;
            trunc_in    = 1'b0;
         end else begin
            nonempty_in = 1'b1;
            if (cfg.mode == MODE_SUBSTRING) begin
               if (fill_ff < KEY_CNT_W'(KEYWORD_CHARS)) begin
                  fill_in = fill_ff + 1'b1;
               end
               if (cfg.key_len != '0 && fill_in >= cfg.key_len && win_eq) begin
                  seen_in = 1'b1;
               end
            end else if (!trunc_ff) begin
               if (step_char == SPACE_CHAR && dash_ff == DASH_SPACE_DASH) begin
                  // " - " found: close the word, ignore the rest of the line
                  trunc_in = 1'b1;
                  seen_in  = seen_ff | word_hit;
                  pos_in   = '0;
                  mism_in  = 1'b0;
               end else begin
                  if (step_char == SPACE_CHAR) begin
                     dash_in = DASH_SPACE;
                  end else if (step_char == DASH_CHAR && dash_ff == DASH_SPACE) begin
                     dash_in = DASH_SPACE_DASH;
                  end else begin
                     dash_in = DASH_NONE;
                  end
                  if (is_alnum(step_char)) begin
                     if (pos_ff < cfg.key_len && lc != cfg.key[pos_ff[KW_IDX_W-1:0]]) begin
                        mism_in = 1'b1;
                     end
                     if (pos_ff <= KEY_CNT_W'(KEYWORD_CHARS)) begin
                        pos_in = pos_ff + 1'b1;
                     end
                  end else begin
                     seen_in = seen_ff | word_hit;
                     pos_in  = '0;
                     mism_in = 1'b0;
                  end
               end
            end
         end
      end
   end

   // verdict for an end-of-line word, from the state before it
   always_comb begin
      if (cfg.mode == MODE_SUBSTRING) begin
         hit = nonempty_ff && (cfg.key_len == '0 || seen_ff);
      end else begin
         hit = (cfg.key_len != '0) && (seen_ff || (!trunc_ff && word_hit));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff     <= '0;
         nonempty_ff <= 1'b0;
         seen_ff     <= 1'b0;
         pos_ff      <= '0;
         mism_ff     <= 1'b0;
         dash_ff     <= DASH_NONE;
         trunc_ff    <= 1'b0;
      end else begin
         fill_ff     <= fill_in;
         nonempty_ff <= nonempty_in;
         seen_ff     <= seen_in;
         pos_ff      <= pos_in;
         mism_ff     <= mism_in;
         dash_ff     <= dash_in;
         trunc_ff    <= trunc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step_valid && !step_eol && cfg.mode == MODE_SUBSTRING) begin
         recent_ff <= recent_in;
      end
   end

endmodule

@@ hw/rtl/keyword_line_matcher.sv @@
// Keyword line matcher. Text arrives on req_ one byte per word; a word with
// req_tlast high closes the line, carries no character, and produces exactly
// one rsp_ word whose bit 0 says whether the line matched. Byte words produce
// no response. Throughput is one word per clock: a word is registered on
// entry, the line state is updated by one pass of compare logic (the 8-byte
// window compare runs in parallel), and the verdict lands in a response
// register. The input side only stalls when an end-of-line word waits in the
// entry register, a verdict is held in the response register and rsp_tready
// is low. Registers are written over csr_ (index 0 mode, 1 keyword bytes,
// 2 keyword length) while the stream is idle: a user rule, not enforced.
module keyword_line_matcher
   import kwm_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [7:0]             req_tdata,   // [7:0] text_char
   input  logic                   req_tlast,   // end_of_line
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [7:0]             rsp_tdata,   // [0] line_matched, [7:1] zero
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [KEY_DATA_W-1:0]  csr_data
);

   kwm_cfg_type       cfg;
   logic              in_valid_ff;
   logic [CHAR_W-1:0] in_char_ff;
   logic              in_eol_ff;
   logic              rsp_valid_ff;
   logic              rsp_data_ff;
   logic              step;
   logic              hit;

   kwm_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // a byte word always moves on; an end-of-line word needs room for its result
   assign step       = in_valid_ff && (!in_eol_ff || !rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || step;

   kwm_match_core u_core (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .step_valid (step),
      .step_char  (in_char_ff),
      .step_eol   (in_eol_ff),
      .hit        (hit)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (step && in_eol_ff) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_char_ff <= req_tdata;
         in_eol_ff  <= req_tlast;
      end
      if (step && in_eol_ff) begin
         rsp_data_ff <= hit;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_data_ff};

endmodule

@@ test/tb.sv @@
`timescale 1ns / 100ps

module tb;
   import kwm_pkg::*;

   localparam int IDLE_LIMIT   = 3000;
   localparam int DRAIN_CYCLES = 4;
   localparam int REPORT_CAP   = 100;
   // index 3 decodes to nothing; writes there must be ignored
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE = 2'd3;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [7:0]             req_tdata = '0;   // [7:0] text_char
   logic                   req_tlast = 1'b0; // end_of_line
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [7:0]             rsp_tdata;        // [0] line_matched, [7:1] zero
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_MATCH_MODE;
   logic [KEY_DATA_W-1:0]  csr_data = '0;

   keyword_line_matcher DUT (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // register copies
   match_mode_type  mode_reg = MODE_SUBSTRING;
   logic [63:0]     key_reg = '0;
   logic [3:0]      key_len_reg = '0;

   // per-line scan state
   logic [7:0] window [KEYWORD_CHARS];
   int         window_count;
   int         word_count;
   int         dash_step;
   bit         line_has_text;
   bit         line_hit;
   bit         word_differs;
   bit         line_cut;

   bit         verdicts_due [$];
   logic [7:0] line_buf [$];
   int         error_count = 0;
   int         idle_cycles = 0;
   int         hold_cycles = 0;
   bit         send_gaps = 1'b0;
   bit         rsp_stalls = 1'b0;

   task automatic report(string what);
      error_count++;
      if (error_count <= REPORT_CAP) begin
         $display("tb: mismatch at %0t: %s", $time, what);
      end
   endtask

   function automatic logic [7:0] fold_case(logic [7:0] c);
      return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
   endfunction

   function automatic bit word_char(logic [7:0] c);
      return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
   endfunction

   function automatic int active_len();
      return (key_len_reg > KEYWORD_CHARS) ? KEYWORD_CHARS : int'(key_len_reg);
   endfunction

   function automatic logic [7:0] key_byte(int i);
      return fold_case(key_reg[i*8 +: 8]);
   endfunction

   function automatic void clear_line();
      int i;
      for (i = 0; i < KEYWORD_CHARS; i++) begin
         window[i] = 8'h00;
      end
      window_count = 0;
      word_count = 0;
      dash_step = 0;
      line_has_text = 1'b0;
      line_hit = 1'b0;
      word_differs = 1'b0;
      line_cut = 1'b0;
   endfunction

   function automatic void close_word();
      int n;
      n = active_len();
      if (word_count != 0 && n != 0 && word_count == n && !word_differs) begin
         line_hit = 1'b1;
      end
      word_count = 0;
      word_differs = 1'b0;
   endfunction

   function automatic void scan_substring(logic [7:0] c);
      int  n;
      int  i;
      bit  same;
      n = active_len();
      same = 1'b1;
      for (i = KEYWORD_CHARS - 1; i > 0; i--) begin
         window[i] = window[i-1];
      end
      window[0] = fold_case(c);
      if (window_count < KEYWORD_CHARS) begin
         window_count++;
      end
      if (n == 0 || window_count < n) begin
         return;
      end
      // window[n-1] holds the oldest byte of the candidate
      for (i = 0; i < n; i++) begin
         if (window[n-1-i] != key_byte(i)) begin
            same = 1'b0;
         end
      end
      if (same) begin
         line_hit = 1'b1;
      end
   endfunction

   function automatic void scan_word(logic [7:0] c);
      if (line_cut) begin
         return;
      end
      if (c == " ") begin
         if (dash_step == 2) begin
            line_cut = 1'b1;
            close_word();
            return;
         end
         dash_step = 1;
      end else if (c == "-" && dash_step == 1) begin
         dash_step = 2;
      end else begin
         dash_step = 0;
      end
      if (word_char(c)) begin
         if (word_count < active_len() && fold_case(c) != key_byte(word_count)) begin
            word_differs = 1'b1;
         end
         if (word_count <= KEYWORD_CHARS) begin
            word_count++;
         end
      end else begin
         close_word();
      end
   endfunction

   function automatic void predict_item(logic [7:0] ch, logic eol);
      bit hit;
      if (!eol) begin
         line_has_text = 1'b1;
         if (mode_reg == MODE_SUBSTRING) begin
            scan_substring(ch);
         end else begin
            scan_word(ch);
         end
         return;
      end
      if (mode_reg == MODE_SUBSTRING) begin
         hit = line_has_text && (active_len() == 0 || line_hit);
      end else begin
         if (!line_cut) begin
            close_word();
         end
         hit = active_len() != 0 && line_hit;
      end
      verdicts_due.push_back(hit);
      clear_line();
   endfunction

   task automatic send_item(logic [7:0] ch, logic eol);
      int gap;
      if (send_gaps && $urandom_range(0, 7) == 0) begin
         gap = $urandom_range(1, 13);
         @(negedge clock);
         req_tvalid = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid = 1'b1;
      req_tdata = ch;
      req_tlast = eol;
      do @(posedge clock); while (!req_tready);
      predict_item(ch, eol);
   endtask

   task automatic send_line(bit close);
      foreach (line_buf[k]) begin
         send_item(line_buf[k], 1'b0);
      end
      if (close) begin
         send_item(8'($urandom), 1'b1);
      end
   endtask

   // wait until every verdict is in and the pipeline has emptied
   task automatic settle();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (verdicts_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_INDEX_W-1:0] idx, logic [63:0] value);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data = value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_MATCH_MODE:     mode_reg = match_mode_type'(value[0]);
         CSR_KEYWORD_BYTES:  key_reg = value;
         CSR_KEYWORD_LENGTH: key_len_reg = value[3:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic set_config(match_mode_type mode, logic [63:0] key, logic [63:0] len);
      write_reg(CSR_MATCH_MODE, 64'(mode));
      write_reg(CSR_KEYWORD_BYTES, key);
      write_reg(CSR_KEYWORD_LENGTH, len);
   endtask

   function automatic logic [7:0] pick_alnum();
      int r;
      r = $urandom_range(0, 61);
      return 8'(r < 10 ? 48 + r : (r < 36 ? 55 + r : 61 + r));
   endfunction

   function automatic logic [7:0] pick_sep();
      case ($urandom_range(0, 5))
         0: return " ";
         1: return "-";
         2: return 8'h00;
         3: return ".";
         4: return 8'($urandom_range(128, 255));
         default: return "_";
      endcase
   endfunction

   function automatic logic [63:0] pick_key();
      logic [63:0] k;
      int          i;
      k = '0;
      case ($urandom_range(0, 5))
         0: k = '0;
         1: k = '1;
         2: k = {$urandom, $urandom};
         default: begin
            for (i = 0; i < KEYWORD_CHARS; i++) begin
               k[i*8 +: 8] = pick_alnum();
            end
         end
      endcase
      return k;
   endfunction

   function automatic logic [63:0] pick_len();
      case ($urandom_range(0, 5))
         0: return 64'd0;
         1: return 64'd8;
         2: return 64'($urandom_range(9, 15));
         default: return 64'($urandom_range(1, 8));
      endcase
   endfunction

   // lines mix keyword copies with scrambled case, keyword prefixes, separators and random bytes
   function automatic void make_line();
      int         pieces;
      int         i;
      int         j;
      int         n;
      int         stop;
      logic [7:0] c;
      line_buf.delete();
      pieces = $urandom_range(0, 5);
      n = active_len();
      for (i = 0; i < pieces; i++) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
               for (j = 0; j < n; j++) begin
                  c = key_reg[j*8 +: 8];
                  if (word_char(c) && c >= "A" && $urandom_range(0, 1) == 1) begin
                     c = c ^ 8'h20;
                  end
                  line_buf.push_back(c);
               end
            end
            4: line_buf.push_back(" ");
            5: begin
               line_buf.push_back(" ");
               line_buf.push_back("-");
               line_buf.push_back(" ");
            end
            6: line_buf.push_back(pick_sep());
            7: repeat ($urandom_range(1, 4)) line_buf.push_back(pick_alnum());
            8: repeat ($urandom_range(1, 6)) line_buf.push_back(8'($urandom));
            default: begin
               stop = $urandom_range(0, n);
               for (j = 0; j < stop; j++) begin
                  line_buf.push_back(key_reg[j*8 +: 8]);
               end
            end
         endcase
      end
      if ($urandom_range(0, 15) == 0) begin
         repeat (20) line_buf.push_back(8'($urandom));
      end
   endfunction

   task automatic random_config();
      if ($urandom_range(0, 3) != 0) begin
         write_reg(CSR_MATCH_MODE, {$urandom, $urandom});
      end
      if ($urandom_range(0, 5) == 0) begin
         write_reg(CSR_SPARE, {$urandom, $urandom});
      end
      if ($urandom_range(0, 1) == 0) begin
         write_reg(CSR_KEYWORD_BYTES, pick_key());
         write_reg(CSR_KEYWORD_LENGTH, pick_len());
      end else begin
         write_reg(CSR_KEYWORD_LENGTH, pick_len());
         if ($urandom_range(0, 3) != 0) begin
            write_reg(CSR_KEYWORD_BYTES, pick_key());
         end
      end
   endtask

   task automatic test_reset_defaults();
      // empty line never matches; empty keyword matches any non-empty line
      send_item(8'h00, 1'b1);
      send_item(8'hff, 1'b0);
      send_item(8'h00, 1'b1);
   endtask

   task automatic test_substring();
      settle();
      set_config(MODE_SUBSTRING, 64'h4261, 64'd2);
      send_item("x", 1'b0);
      send_item("A", 1'b0);
      send_item("b", 1'b0);
      send_item(8'hff, 1'b1);
   endtask

   task automatic test_whole_word();
      settle();
      write_reg(CSR_MATCH_MODE, 64'(MODE_WHOLE_WORD));
      send_item("A", 1'b0);
      send_item("B", 1'b0);
      send_item("-", 1'b0);
      send_item("c", 1'b0);
      send_item(8'h00, 1'b1);
      // keyword only after space-dash-space: ignored
      send_item(" ", 1'b0);
      send_item("-", 1'b0);
      send_item(" ", 1'b0);
      send_item("a", 1'b0);
      send_item("b", 1'b0);
      send_item(8'h00, 1'b1);
   endtask

   task automatic test_midline_change();
      settle();
      write_reg(CSR_MATCH_MODE, 64'(MODE_SUBSTRING));
      send_item("q", 1'b0);
      settle();
      set_config(MODE_WHOLE_WORD, 64'h71, 64'd15);
      send_item(8'h00, 1'b1);
   endtask

   task automatic test_random_lines(int phases, int per_phase, bit steady);
      int p;
      int sent;
      for (p = 0; p < phases; p++) begin
         settle();
         random_config();
         if (steady) begin
            send_gaps = 1'b0;
            rsp_stalls = 1'b0;
         end else begin
            send_gaps = (p % 4 != 3);
            rsp_stalls = (p % 4 != 2);
         end
         sent = 0;
         while (sent < per_phase) begin
            make_line();
            send_line(1'b1);
            sent += line_buf.size() + 1;
         end
         // sometimes leave a line open across the next register change
         if ($urandom_range(0, 2) == 0) begin
            make_line();
            send_line(1'b0);
         end
      end
   endtask

   task automatic test_backpressure();
      int i;
      settle();
      set_config(MODE_SUBSTRING, {$urandom, $urandom}, 64'd1);
      send_gaps = 1'b0;
      rsp_stalls = 1'b0;
      hold_cycles = 150;
      for (i = 0; i < 30; i++) begin
         make_line();
         send_line(1'b1);
      end
   endtask

   task automatic test_steady_stream();
      send_gaps = 1'b0;
      rsp_stalls = 1'b0;
      test_random_lines(3, 50, 1'b1);
   endtask

   // response side: random stall bursts, plus one long hold-off on request
   initial begin
      forever begin
         @(negedge clock);
         if (hold_cycles > 0) begin
            rsp_tready = 1'b0;
            repeat (hold_cycles - 1) @(negedge clock);
            hold_cycles = 0;
         end else if (rsp_stalls && $urandom_range(0, 7) == 0) begin
            rsp_tready = 1'b0;
            repeat ($urandom_range(1, 13) - 1) @(negedge clock);
         end else begin
            rsp_tready = 1'b1;
         end
      end
   end

   always @(posedge clock) begin : check_rsp
      bit want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (verdicts_due.size() == 0) begin
            report($sformatf("response word %h with no line pending", rsp_tdata));
         end else begin
            want = verdicts_due.pop_front();
            if (rsp_tdata !== {7'd0, want}) begin
               report($sformatf("line_matched word %h, want %0d", rsp_tdata, want));
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("tb: done, errors");
         $finish;
      end
   end

   initial begin
      clear_line();
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      send_gaps = 1'b1;
      rsp_stalls = 1'b1;
      test_reset_defaults();
      test_substring();
      test_whole_word();
      test_midline_change();
      test_random_lines(22, 50, 1'b0);
      test_backpressure();
      test_steady_stream();
      settle();
      repeat (8) @(posedge clock);
      if (verdicts_due.size() != 0) begin
         report($sformatf("%0d verdicts never arrived", verdicts_due.size()));
      end
      if (error_count == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end

endmodule
